[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL.
// No dependencies; SYNTH compiles them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define DCALU_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DCALU_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define DCALU_ASSERT(lbl, clk, rst_n, prop, msg)
`define DCALU_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

[rtl/core/dcalu_pkg.sv]
// Types, opcodes and constants of the DCPU-16 basic ALU.
// No dependencies.
package dcalu_pkg;

	typedef enum logic [4:0] {
		OP_SPECIAL = 5'd0,  OP_SET = 5'd1,  OP_ADD = 5'd2,  OP_SUB = 5'd3,
		OP_MUL = 5'd4,      OP_MLI = 5'd5,  OP_DIV = 5'd6,  OP_DVI = 5'd7,
		OP_MOD = 5'd8,      OP_MDI = 5'd9,  OP_AND = 5'd10, OP_BOR = 5'd11,
		OP_XOR = 5'd12,     OP_SHR = 5'd13, OP_ASR = 5'd14, OP_SHL = 5'd15,
		OP_IFB = 5'd16,     OP_IFC = 5'd17, OP_IFE = 5'd18, OP_IFN = 5'd19,
		OP_IFG = 5'd20,     OP_IFA = 5'd21, OP_IFL = 5'd22, OP_IFU = 5'd23,
		OP_ADX = 5'd26,     OP_SBX = 5'd27, OP_STI = 5'd30, OP_STD = 5'd31
	} op_t;

	localparam logic [1:0] STEP_NONE = 2'b00;
	localparam logic [1:0] STEP_INC  = 2'b01;
	localparam logic [1:0] STEP_DEC  = 2'b11;

	localparam logic [15:0] MASK16 = 16'hFFFF;

	localparam logic [1:0] CYCLE_TABLE [32] = '{
		2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3,
		2'd3, 2'd3, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
		2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
		2'd0, 2'd0, 2'd3, 2'd3, 2'd0, 2'd0, 2'd2, 2'd2
	};

	// divider: 32 quotient bits, BITS_PER_STG per pipeline stage
	localparam int QUO_BITS     = 32;
	localparam int BITS_PER_STG = 2;
	localparam int DIV_STAGES   = QUO_BITS / BITS_PER_STG;
	localparam int MOD_BIT      = 15;

	typedef struct packed {
		logic [15:0] res;
		logic        wb;
		logic [15:0] nex;
		logic        wex;
		logic        skip;
		logic [1:0]  step;
		logic [1:0]  cycles;
		logic        div_en;
		logic        is_mod;
		logic        div_zero;
		logic        neg_q;
		logic        neg_r;
		logic [15:0] dvd;
		logic [15:0] dvs;
	} dcalu_item_t;

	typedef struct packed {
		dcalu_item_t item;
		logic [15:0] rem;
		logic [15:0] dvd_sh;
		logic [31:0] quo;
		logic [15:0] rmod;
	} dcalu_div_t;

	// one restoring step: {quotient bit, new remainder}
	function automatic logic [16:0] div_step(input logic [15:0] rem, input logic dbit,
		input logic [15:0] dvs);
		logic [16:0] t;
		logic [16:0] d;
		begin
			t = {rem, dbit};
			d = t - {1'b0, dvs};
			if (t >= {1'b0, dvs}) begin
				div_step = {1'b1, d[15:0]};
			end else begin
				div_step = {1'b0, t[15:0]};
			end
		end
	endfunction

endpackage

[rtl/core/dcpu16_basic_alu.sv]
// DCPU-16 basic-opcode execute stage, top level.
// Depends on dcalu_pkg, dcalu_front, dcalu_fifo, dcalu_back, assert_macros.svh.
//
// Input channel in_valid/in_ready carries req_type, b_value, a_value, ex_in.
// Output channel out_valid/out_ready carries result_value, write_back,
// ex_value, ex_write, skip_next, index_step, base_cycles.
// Items are decoded on entry and queued (FIFO_DEPTH entries); the back end
// pulls one per cycle while the output is not stalled into a 16-stage
// divider pipeline (two quotient bits per stage) that every opcode passes
// through, then a result register.
// Throughput: one item per cycle unless the output stalls, in order.
// in_ready depends only on queue fill; when out_valid is high and out_ready
// is low the back pipeline holds and the queue fills up to FIFO_DEPTH items.
// Reset clears the queue and all valid bits; no clearing pass is needed.
`include "assert_macros.svh"
module dcpu16_basic_alu #(
	parameter int FIFO_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [4:0]         req_type,
	input  logic [15:0]        b_value,
	input  logic [15:0]        a_value,
	input  logic [15:0]        ex_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        result_value,
	output logic               write_back,
	output logic [15:0]        ex_value,
	output logic               ex_write,
	output logic               skip_next,
	output logic signed [1:0]  index_step,
	output logic [1:0]         base_cycles
);

	dcalu_pkg::dcalu_item_t dec_item;
	dcalu_pkg::dcalu_item_t head_item;
	logic fifo_push;
	logic fifo_pop;
	logic fifo_full;
	logic fifo_empty;

	assign in_ready  = !fifo_full;
	assign fifo_push = in_valid && !fifo_full;

	dcalu_front u_front (
		.req_type (req_type),
		.b_value  (b_value),
		.a_value  (a_value),
		.ex_in    (ex_in),
		.item     (dec_item)
	);

	dcalu_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fifo_push),
		.wr_item (dec_item),
		.pop     (fifo_pop),
		.rd_item (head_item),
		.full    (fifo_full),
		.empty   (fifo_empty)
	);

	dcalu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (!fifo_empty),
		.head_item    (head_item),
		.pop          (fifo_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.write_back   (write_back),
		.ex_value     (ex_value),
		.ex_write     (ex_write),
		.skip_next    (skip_next),
		.index_step   (index_step),
		.base_cycles  (base_cycles)
	);

	`DCALU_ASSERT(a_no_pop_empty, clk, arst_n, fifo_empty |-> !fifo_pop, "pop from empty queue")
	`DCALU_ASSERT(a_no_pop_stall, clk, arst_n, (out_valid && !out_ready) |-> !fifo_pop, "pop while stalled")
	`DCALU_ASSERT(a_skip_no_wb, clk, arst_n, (out_valid && skip_next) |-> !write_back, "test wrote b")
	`DCALU_ASSERT_NEXT(a_push_fills, clk, arst_n, (fifo_push && !fifo_pop), !fifo_empty, "item lost in queue")

endmodule

[rtl/core/dcalu_front.sv]
// Front decode: classifies the opcode, computes all non-divide results
// and prepares divider operands. Depends on dcalu_pkg.
module dcalu_front (
	input  logic [4:0]              req_type,
	input  logic [15:0]             b_value,
	input  logic [15:0]             a_value,
	input  logic [15:0]             ex_in,
	output dcalu_pkg::dcalu_item_t  item
);

	logic signed [16:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [33:0] prod;
	logic [16:0]        sum;
	logic [17:0]        sum_x;
	logic [17:0]        diff_x;
	logic [31:0]        shr_w;
	logic [31:0]        shl_w;
	logic [15:0]        asr_r;
	logic [3:0]         asr_sh;
	logic               big_sh;
	logic               sgn;
	logic               sb_lt;
	logic               sa_lt;

	assign sgn    = (req_type == dcalu_pkg::OP_MLI);
	assign mul_a  = {sgn & a_value[15], a_value};
	assign mul_b  = {sgn & b_value[15], b_value};
	assign prod   = mul_a * mul_b;
	assign sum    = {1'b0, b_value} + {1'b0, a_value};
	assign sum_x  = {2'b00, b_value} + {2'b00, a_value} + {2'b00, ex_in};
	assign diff_x = {2'b00, b_value} - {2'b00, a_value} + {2'b00, ex_in};
	assign big_sh = |a_value[15:5];
	assign shr_w  = {b_value, 16'h0000} >> a_value[4:0];
	assign shl_w  = {16'h0000, b_value} << a_value[4:0];
	assign asr_sh = (a_value > 16'd15) ? 4'd15 : a_value[3:0];
	assign asr_r  = $unsigned($signed(b_value) >>> asr_sh);
	assign sb_lt  = $signed(b_value) < $signed(a_value);
	assign sa_lt  = $signed(a_value) < $signed(b_value);

	always_comb begin
		item          = '0;
		item.res      = b_value;
		item.nex      = ex_in;
		item.step     = dcalu_pkg::STEP_NONE;
		item.cycles   = dcalu_pkg::CYCLE_TABLE[req_type];
		item.div_zero = (a_value == 16'h0000);
		item.dvd      = b_value;
		item.dvs      = a_value;
		case (req_type)
			dcalu_pkg::OP_SET: begin
				item.res = a_value;
				item.wb  = 1'b1;
			end
			dcalu_pkg::OP_ADD: begin
				item.res = sum[15:0];
				item.nex = {15'h0000, sum[16]};
				item.wb  = 1'b1;
				item.wex = 1'b1;
			end
			dcalu_pkg::OP_SUB: begin
				item.res = b_value - a_value;
				item.nex = (b_value < a_value) ? dcalu_pkg::MASK16 : 16'h0000;
				item.wb  = 1'b1;
				item.wex = 1'b1;
			end
			dcalu_pkg::OP_MUL, dcalu_pkg::OP_MLI: begin
				item.res = prod[15:0];
				item.nex = prod[31:16];
				item.wb  = 1'b1;
				item.wex = 1'b1;
			end
			dcalu_pkg::OP_DIV, dcalu_pkg::OP_MOD: begin
				item.div_en = 1'b1;
				item.is_mod = (req_type == dcalu_pkg::OP_MOD);
				item.wb     = 1'b1;
				item.wex    = (req_type == dcalu_pkg::OP_DIV);
			end
			dcalu_pkg::OP_DVI, dcalu_pkg::OP_MDI: begin
				item.div_en = 1'b1;
				item.is_mod = (req_type == dcalu_pkg::OP_MDI);
				item.wb     = 1'b1;
				item.wex    = (req_type == dcalu_pkg::OP_DVI);
				item.neg_q  = b_value[15] ^ a_value[15];
				item.neg_r  = b_value[15];
				item.dvd    = b_value[15] ? (16'h0000 - b_value) : b_value;
				item.dvs    = a_value[15] ? (16'h0000 - a_value) : a_value;
			end
			dcalu_pkg::OP_AND: begin
				item.res = b_value & a_value;
				item.wb  = 1'b1;
			end
			dcalu_pkg::OP_BOR: begin
				item.res = b_value | a_value;
				item.wb  = 1'b1;
			end
			dcalu_pkg::OP_XOR: begin
				item.res = b_value ^ a_value;
				item.wb  = 1'b1;
			end
			dcalu_pkg::OP_SHR: begin
				item.res = big_sh ? 16'h0000 : shr_w[31:16];
				item.nex = big_sh ? 16'h0000 : shr_w[15:0];
				item.wb  = 1'b1;
				item.wex = 1'b1;
			end
			dcalu_pkg::OP_ASR: begin
				item.res = asr_r;
				item.nex = big_sh ? 16'h0000 : shr_w[15:0];
				item.wb  = 1'b1;
				item.wex = 1'b1;
			end
			dcalu_pkg::OP_SHL: begin
				item.res = big_sh ? 16'h0000 : shl_w[15:0];
				item.nex = big_sh ? 16'h0000 : shl_w[31:16];
				item.wb  = 1'b1;
				item.wex = 1'b1;
			end
			dcalu_pkg::OP_IFB: item.skip = ((b_value & a_value) == 16'h0000);
			dcalu_pkg::OP_IFC: item.skip = ((b_value & a_value) != 16'h0000);
			dcalu_pkg::OP_IFE: item.skip = (b_value != a_value);
			dcalu_pkg::OP_IFN: item.skip = (b_value == a_value);
			dcalu_pkg::OP_IFG: item.skip = (b_value <= a_value);
			dcalu_pkg::OP_IFA: item.skip = !sa_lt;
			dcalu_pkg::OP_IFL: item.skip = (b_value >= a_value);
			dcalu_pkg::OP_IFU: item.skip = !sb_lt;
			dcalu_pkg::OP_ADX: begin
				item.res = sum_x[15:0];
				item.nex = (sum_x[17:16] != 2'b00) ? 16'h0001 : 16'h0000;
				item.wb  = 1'b1;
				item.wex = 1'b1;
			end
			dcalu_pkg::OP_SBX: begin
				item.res = diff_x[15:0];
				item.nex = diff_x[17] ? dcalu_pkg::MASK16 :
					(diff_x[16] ? 16'h0001 : 16'h0000);
				item.wb  = 1'b1;
				item.wex = 1'b1;
			end
			dcalu_pkg::OP_STI: begin
				item.res  = a_value;
				item.wb   = 1'b1;
				item.step = dcalu_pkg::STEP_INC;
			end
			dcalu_pkg::OP_STD: begin
				item.res  = a_value;
				item.wb   = 1'b1;
				item.step = dcalu_pkg::STEP_DEC;
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/core/dcalu_fifo.sv]
// Short item queue between front decode and back pipeline.
// Depends on dcalu_pkg.
module dcalu_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  dcalu_pkg::dcalu_item_t wr_item,
	input  logic                   pop,
	output dcalu_pkg::dcalu_item_t rd_item,
	output logic                   full,
	output logic                   empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	dcalu_pkg::dcalu_item_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

[rtl/core/dcalu_back.sv]
// Back pipeline: radix-2 restoring divider stages plus result register.
// Non-divide items ride along unchanged. Depends on dcalu_pkg.
module dcalu_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  dcalu_pkg::dcalu_item_t head_item,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [15:0]            result_value,
	output logic                   write_back,
	output logic [15:0]            ex_value,
	output logic                   ex_write,
	output logic                   skip_next,
	output logic signed [1:0]      index_step,
	output logic [1:0]             base_cycles
);

	localparam int NS = dcalu_pkg::DIV_STAGES;

	dcalu_pkg::dcalu_div_t div_stage_q [NS];
	dcalu_pkg::dcalu_div_t div_next [NS];
	logic [NS-1:0]         valid_q;
	logic                  en;
	logic                  out_valid_q;
	dcalu_pkg::dcalu_item_t fin;
	dcalu_pkg::dcalu_div_t  last;

	assign en  = !out_valid_q || out_ready;
	assign pop = en && head_valid;

	always_comb begin
		dcalu_pkg::dcalu_div_t cur;
		logic [16:0] st;
		for (int s = 0; s < NS; s++) begin
			if (s == 0) begin
				cur        = '0;
				cur.item   = head_item;
				cur.dvd_sh = head_item.dvd;
			end else begin
				cur = div_stage_q[s-1];
			end
			for (int j = 0; j < dcalu_pkg::BITS_PER_STG; j++) begin
				st         = dcalu_pkg::div_step(cur.rem, cur.dvd_sh[15], cur.item.dvs);
				cur.rem    = st[15:0];
				cur.quo    = {cur.quo[30:0], st[16]};
				cur.dvd_sh = {cur.dvd_sh[14:0], 1'b0};
				if (s * dcalu_pkg::BITS_PER_STG + j == dcalu_pkg::MOD_BIT) begin
					cur.rmod = st[15:0];
				end
			end
			div_next[s] = cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_q     <= {valid_q[NS-2:0], head_valid};
			out_valid_q <= valid_q[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < NS; s++) begin
				div_stage_q[s] <= div_next[s];
			end
		end
	end

	// sign fixup and divide-by-zero
	always_comb begin
		last = div_stage_q[NS-1];
		fin  = last.item;
		if (last.item.div_en) begin
			if (last.item.div_zero) begin
				fin.res = 16'h0000;
				if (!last.item.is_mod) begin
					fin.nex = 16'h0000;
				end
			end else if (last.item.is_mod) begin
				fin.res = last.item.neg_r ? (16'h0000 - last.rmod) : last.rmod;
			end else begin
				fin.res = last.item.neg_q ? (16'h0000 - last.quo[31:16]) : last.quo[31:16];
				fin.nex = last.item.neg_q ? (16'h0000 - last.quo[15:0]) : last.quo[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_value <= fin.res;
			write_back   <= fin.wb;
			ex_value     <= fin.nex;
			ex_write     <= fin.wex;
			skip_next    <= fin.skip;
			index_step   <= $signed(fin.step);
			base_cycles  <= fin.cycles;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[tb/tb_dcpu16_basic_alu.sv]
// Self-checking testbench for dcpu16_basic_alu: directed opcode corners, then random items,
// with random idling on both valid/ready channels and a long receiver hold-off.
// Depends on dcalu_pkg and the dcpu16_basic_alu RTL.
module tb_dcpu16_basic_alu;
	timeunit 1ns;
	timeprecision 1ps;
	import dcalu_pkg::*;

	typedef struct packed {
		logic [15:0] res;
		logic        wb;
		logic [15:0] nex;
		logic        wex;
		logic        skip;
		logic [1:0]  step;
		logic [1:0]  cyc;
	} alu_out_t;

	typedef struct {
		op_t         op;
		logic [15:0] b;
		logic [15:0] a;
		logic [15:0] ex;
		bit          fixed;
		alu_out_t    want;
	} vec_t;

	localparam logic [1:0] OP_COST [32] = '{
		2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3,
		2'd3, 2'd3, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
		2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
		2'd0, 2'd0, 2'd3, 2'd3, 2'd0, 2'd0, 2'd2, 2'd2
	};
	localparam int N_RANDOM = 1500;
	localparam alu_out_t NONE = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_ready;
	logic [4:0] req_type = '0;
	logic [15:0] b_value = '0, a_value = '0, ex_in = '0;
	logic out_valid, out_ready = 1'b0;
	logic [15:0] result_value, ex_value;
	logic write_back, ex_write, skip_next;
	logic signed [1:0] index_step;
	logic [1:0] base_cycles;

	alu_out_t pending_results[$];
	int n_sent = 0, n_checked = 0, n_errors = 0;
	bit hold_done = 1'b0;

	dcpu16_basic_alu u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic alu_out_t alu_result(logic [4:0] op, logic [15:0] b, logic [15:0] a,
		logic [15:0] ex);
		alu_out_t r;
		longint sb, sa, q;
		logic [63:0] w;
		int d;
		int unsigned u;
		sb = longint'($signed(b));
		sa = longint'($signed(a));
		r = '{res: b, wb: 1'b0, nex: ex, wex: 1'b0, skip: 1'b0, step: STEP_NONE,
			cyc: OP_COST[op]};
		case (op)
		OP_SET: begin r.res = a; r.wb = 1'b1; end
		OP_ADD: begin u = 32'(b) + 32'(a); r.res = u[15:0]; r.nex = u[31:16]; r.wb = 1; r.wex = 1; end
		OP_SUB: begin r.res = b - a; r.nex = (b < a) ? MASK16 : 16'h0; r.wb = 1; r.wex = 1; end
		OP_MUL: begin u = 32'(b) * 32'(a); r.res = u[15:0]; r.nex = u[31:16]; r.wb = 1; r.wex = 1; end
		OP_MLI: begin q = sb * sa; r.res = q[15:0]; r.nex = q[31:16]; r.wb = 1; r.wex = 1; end
		OP_DIV: begin
			r.wb = 1; r.wex = 1;
			if (a == 0) begin
				r.res = 0; r.nex = 0;
			end else begin
				r.res = b / a;
				w = 64'({b, 16'h0}) / 64'(a);
				r.nex = w[15:0];
			end
		end
		OP_DVI: begin
			r.wb = 1; r.wex = 1;
			if (a == 0) begin
				r.res = 0; r.nex = 0;
			end else begin
				q = sb / sa; r.res = q[15:0];
				q = (sb * 65536) / sa; r.nex = q[15:0];
			end
		end
		OP_MOD: begin r.res = (a == 0) ? 16'h0 : b % a; r.wb = 1; end
		OP_MDI: begin
			q = (a == 0) ? 0 : sb % sa;
			r.res = q[15:0]; r.wb = 1;
		end
		OP_AND: begin r.res = b & a; r.wb = 1; end
		OP_BOR: begin r.res = b | a; r.wb = 1; end
		OP_XOR: begin r.res = b ^ a; r.wb = 1; end
		OP_SHR: begin
			w = 64'({b, 16'h0}) >> a;
			r.res = (a >= 32) ? 16'h0 : w[31:16];
			r.nex = (a >= 32) ? 16'h0 : w[15:0];
			r.wb = 1; r.wex = 1;
		end
		OP_ASR: begin
			q = sb >>> ((a > 15) ? 15 : a);
			w = 64'({b, 16'h0}) >> a;
			r.res = q[15:0];
			r.nex = (a >= 32) ? 16'h0 : w[15:0];
			r.wb = 1; r.wex = 1;
		end
		OP_SHL: begin
			w = 64'(b) << a;
			r.res = (a >= 32) ? 16'h0 : w[15:0];
			r.nex = (a >= 32) ? 16'h0 : w[31:16];
			r.wb = 1; r.wex = 1;
		end
		OP_IFB: r.skip = (b & a) == 0;
		OP_IFC: r.skip = (b & a) != 0;
		OP_IFE: r.skip = b != a;
		OP_IFN: r.skip = b == a;
		OP_IFG: r.skip = b <= a;
		OP_IFA: r.skip = sb <= sa;
		OP_IFL: r.skip = b >= a;
		OP_IFU: r.skip = sb >= sa;
		OP_ADX: begin
			u = 32'(b) + 32'(a) + 32'(ex);
			r.res = u[15:0]; r.nex = (u > 32'hFFFF) ? 16'h1 : 16'h0; r.wb = 1; r.wex = 1;
		end
		OP_SBX: begin
			d = int'(b) - int'(a) + int'(ex);
			r.res = d[15:0];
			r.nex = (d < 0) ? MASK16 : ((d > 65535) ? 16'h1 : 16'h0);
			r.wb = 1; r.wex = 1;
		end
		OP_STI: begin r.res = a; r.wb = 1; r.step = STEP_INC; end
		OP_STD: begin r.res = a; r.wb = 1; r.step = STEP_DEC; end
		default: ;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] pick_operand();
		case ($urandom_range(0, 7))
		0: return 16'h0000;
		1: return 16'hFFFF;
		2: return 16'h8000;
		3: return 16'h7FFF;
		4: return 16'h0001;
		5: return 16'($urandom_range(0, 40));
		default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_item(logic [4:0] op, logic [15:0] b, logic [15:0] a, logic [15:0] ex,
		bit fixed, alu_out_t want, bit may_idle);
		while (may_idle && $urandom_range(0, 99) < 28) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		b_value <= b;
		a_value <= a;
		ex_in <= ex;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(fixed ? want : alu_result(op, b, a, ex));
		n_sent++;
		@(negedge clk);
	endtask

	// directed corners; typed expectations where obvious
	vec_t dir_vecs[] = '{
		'{OP_SET, 16'h1234, 16'hFFFF, 16'h0005, 1,
			'{16'hFFFF, 1'b1, 16'h0005, 1'b0, 1'b0, STEP_NONE, 2'd1}},
		'{OP_ADD, 16'hFFFF, 16'hFFFF, 16'h0000, 1,
			'{16'hFFFE, 1'b1, 16'h0001, 1'b1, 1'b0, STEP_NONE, 2'd2}},
		'{OP_DIV, 16'hFFFF, 16'h0000, 16'hABCD, 1,
			'{16'h0000, 1'b1, 16'h0000, 1'b1, 1'b0, STEP_NONE, 2'd3}},
		'{OP_DVI, 16'h8000, 16'h0000, 16'h1111, 1,
			'{16'h0000, 1'b1, 16'h0000, 1'b1, 1'b0, STEP_NONE, 2'd3}},
		'{OP_MOD, 16'h1234, 16'h0000, 16'hABCD, 1,
			'{16'h0000, 1'b1, 16'hABCD, 1'b0, 1'b0, STEP_NONE, 2'd3}},
		'{OP_SPECIAL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1,
			'{16'hFFFF, 1'b0, 16'hFFFF, 1'b0, 1'b0, STEP_NONE, 2'd0}},
		'{op_t'(5'd24), 16'h0001, 16'h0002, 16'h0003, 1,
			'{16'h0001, 1'b0, 16'h0003, 1'b0, 1'b0, STEP_NONE, 2'd0}},
		'{OP_STD, 16'h0000, 16'h8000, 16'h0000, 1,
			'{16'h8000, 1'b1, 16'h0000, 1'b0, 1'b0, STEP_DEC, 2'd2}},
		'{OP_STI, 16'hFFFF, 16'h7FFF, 16'h0000, 0, NONE},
		'{OP_MLI, 16'h8000, 16'h8000, 16'h0000, 0, NONE},
		'{OP_DVI, 16'h8000, 16'hFFFF, 16'h0000, 0, NONE},
		'{OP_MDI, 16'h8000, 16'h0003, 16'h0000, 0, NONE},
		'{OP_MDI, 16'h1234, 16'h0000, 16'h0000, 0, NONE},
		'{OP_SHR, 16'hFFFF, 16'h0020, 16'h0000, 0, NONE},
		'{OP_ASR, 16'h8000, 16'h0028, 16'h0000, 0, NONE},
		'{OP_ASR, 16'h8001, 16'h0010, 16'h0000, 0, NONE},
		'{OP_SHL, 16'hFFFF, 16'h001F, 16'h0000, 0, NONE},
		'{OP_SBX, 16'h0000, 16'hFFFF, 16'h0000, 0, NONE},
		'{OP_SBX, 16'hFFFF, 16'h0000, 16'hFFFF, 0, NONE},
		'{OP_ADX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, NONE},
		'{OP_IFA, 16'h8000, 16'h7FFF, 16'h0000, 0, NONE},
		'{OP_IFU, 16'h8000, 16'h7FFF, 16'h0000, 0, NONE},
		'{OP_IFG, 16'h8000, 16'h7FFF, 16'h0000, 0, NONE},
		'{OP_IFB, 16'h00F0, 16'h0F00, 16'h0000, 0, NONE},
		'{OP_IFE, 16'h5555, 16'h5555, 16'h0000, 0, NONE}
	};

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir_vecs[i])
			send_item(dir_vecs[i].op, dir_vecs[i].b, dir_vecs[i].a, dir_vecs[i].ex,
				dir_vecs[i].fixed, dir_vecs[i].want, 1'b1);
		for (int i = 0; i < N_RANDOM; i++)
			send_item(5'($urandom_range(0, 31)), pick_operand(), pick_operand(),
				pick_operand(), 1'b0, NONE, !(i >= 600 && i < 900));
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Checked %0d results from %0d items: all opcodes, divide/shift corners,",
			n_checked, n_sent);
		$display("random idling on both channels and one long output hold-off.");
		if (n_errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// receiver: random ready, a quiet stretch, and one long hold-off to fill the queue
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (!hold_done && n_sent >= 300) begin
				hold_done = 1'b1;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (n_sent >= 625 && n_sent < 900) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= 28);
			end
		end
	end

	always @(posedge clk) begin
		alu_out_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{result_value, write_back, ex_value, ex_write, skip_next,
				2'(index_step), base_cycles};
			if (pending_results.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected item res=%h wb=%b", $realtime, result_value, write_back);
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (got !== want) begin
					n_errors++;
					$display("%0t: mismatch exp res=%h wb=%b ex=%h wex=%b skip=%b step=%b cyc=%0d",
						$realtime, want.res, want.wb, want.nex, want.wex, want.skip, want.step,
						want.cyc);
					$display("%0t:          got res=%h wb=%b ex=%h wex=%b skip=%b step=%b cyc=%0d",
						$realtime, got.res, got.wb, got.nex, got.wex, got.skip, got.step, got.cyc);
				end
			end
		end
	end

	initial begin
		#2ms;
		$display("Timeout with %0d results outstanding", pending_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/dcalu_pkg.sv
rtl/core/dcalu_front.sv
rtl/core/dcalu_fifo.sv
rtl/core/dcalu_back.sv
rtl/core/dcpu16_basic_alu.sv
tb/tb_dcpu16_basic_alu.sv
